@@ hw/rtl/kme_pkg.sv @@
// ----------------------------------------------------------------------------
// kme_pkg
// Shared types and constants for the keypad mouse emulator.
// ----------------------------------------------------------------------------
package kme_pkg;

   localparam int unsigned KEYS_W    = 7;
   localparam int unsigned CTRL_W    = 6;
   localparam int unsigned DIR_W     = 4;
   localparam int unsigned TIME_W    = 32;
   localparam int unsigned SPEED_W   = 7;
   localparam int unsigned PERIOD_W  = 16;
   localparam int unsigned MOVE_W    = 8;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DAT_W = 16;

   localparam int unsigned KEY_UP     = 0;
   localparam int unsigned KEY_DOWN   = 1;
   localparam int unsigned KEY_LEFT   = 2;
   localparam int unsigned KEY_RIGHT  = 3;
   localparam int unsigned KEY_RCLICK = 4;
   localparam int unsigned KEY_LCLICK = 5;

   // The step size grows by one every SPEED_STEP_MS of holding. The quotient
   // is only needed below 2**SPEED_W, so the divide is a reciprocal multiply
   // over a short operand, exact for every operand below HELD_LIMIT.
   localparam int unsigned SPEED_STEP_MS = 180;
   localparam int unsigned HELD_LIMIT    = SPEED_STEP_MS * (2 ** SPEED_W);
   localparam int unsigned HELD_W        = $clog2(HELD_LIMIT);
   localparam int unsigned RECIP_SHIFT   = 23;
   localparam int unsigned RECIP         = (2 ** RECIP_SHIFT) / SPEED_STEP_MS + 1;
   localparam int unsigned RECIP_W       = $clog2(RECIP + 1);
   localparam int unsigned PROD_W        = HELD_W + RECIP_W;

   localparam logic [SPEED_W-1:0]  BASE_SPEED_RST = SPEED_W'(2);
   localparam logic [SPEED_W-1:0]  MAX_SPEED_RST  = SPEED_W'(18);
   localparam logic [PERIOD_W-1:0] PERIOD_RST     = PERIOD_W'(20);

   typedef enum logic [1:0] {
      OP_HANDLE = 2'd0,
      OP_ENTER  = 2'd1,
      OP_LEAVE  = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_NONE     = 2'd0,
      ST_REPORT   = 2'd1,
      ST_INACTIVE = 2'd2
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BASE_SPEED = 2'd0,
      CSR_MAX_SPEED  = 2'd1,
      CSR_PERIOD     = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [1:0]        opcode;
      logic [KEYS_W-1:0] keys;
      logic [TIME_W-1:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [SPEED_W-1:0]  base_speed;
      logic [SPEED_W-1:0]  max_speed;
      logic [PERIOD_W-1:0] period;
   } cfg_type;

   typedef struct packed {
      status_type               status;
      logic                     left_click;
      logic                     right_click;
      logic signed [MOVE_W-1:0] move_x;
      logic signed [MOVE_W-1:0] move_y;
   } rsp_type;

endpackage

@@ hw/rtl/kme_speed.sv @@
// ----------------------------------------------------------------------------
// kme_speed
// Step size from hold time: min(base + held / 180, max).
// ----------------------------------------------------------------------------
module kme_speed (
   input  logic [kme_pkg::TIME_W-1:0]  held_ms,
   input  kme_pkg::cfg_type            cfg,
   output logic [kme_pkg::SPEED_W-1:0] speed
);
   import kme_pkg::*;

   logic              big;
   logic [PROD_W-1:0] prod;
   logic [SPEED_W-1:0] quot;
   logic [SPEED_W:0]  sum;

   assign big  = (held_ms >= TIME_W'(HELD_LIMIT));
   assign prod = PROD_W'(held_ms[HELD_W-1:0]) * PROD_W'(RECIP);
   assign quot = prod[RECIP_SHIFT +: SPEED_W];
   assign sum  = {1'b0, cfg.base_speed} + {1'b0, quot};

   always_comb begin
      if (big || (sum > {1'b0, cfg.max_speed})) begin
         speed = cfg.max_speed;
      end else begin
         speed = sum[SPEED_W-1:0];
      end
   end

endmodule

@@ hw/rtl/kme_engine.sv @@
// ----------------------------------------------------------------------------
// kme_engine
// Mode state and report decision for one transaction per cycle while fire is high.
// ----------------------------------------------------------------------------
module kme_engine (
   input  logic             clock,
   input  logic             reset,
   input  logic             fire,
   input  kme_pkg::req_type req,
   input  kme_pkg::cfg_type cfg,
   output kme_pkg::rsp_type rsp
);
   import kme_pkg::*;

   logic               active_ff, active_in;
   logic               wait_ff, wait_in;
   logic [CTRL_W-1:0]  prior_ff, prior_in;
   logic               unknown_ff, unknown_in;
   logic [DIR_W-1:0]   held_ff, held_in;
   logic [TIME_W-1:0]  since_ff, since_in;
   logic [TIME_W-1:0]  last_ff, last_in;

   logic [CTRL_W-1:0]  ctrl;
   logic [DIR_W-1:0]   dirs;
   logic               dir_new;
   logic [TIME_W-1:0]  since_eff;
   logic [TIME_W-1:0]  last_eff;
   logic [TIME_W-1:0]  since_last;
   logic               changed;
   logic               due;
   logic [SPEED_W-1:0] speed;
   logic signed [MOVE_W-1:0] step;

   assign ctrl       = req.keys[CTRL_W-1:0];
   assign dirs       = req.keys[DIR_W-1:0];
   assign dir_new    = (dirs != held_ff);
   assign since_eff  = dir_new ? req.now_ms : since_ff;
   assign last_eff   = dir_new ? '0 : last_ff;
   assign since_last = req.now_ms - last_eff;
   assign changed    = unknown_ff || (ctrl != prior_ff);
   assign due        = (dirs != '0) &&
                       ((last_eff == '0) || (since_last >= TIME_W'(cfg.period)));
   assign step       = signed'({1'b0, speed});

   kme_speed u_speed (
      .held_ms (req.now_ms - since_eff),
      .cfg     (cfg),
      .speed   (speed)
   );

   always_comb begin
      active_in  = active_ff;
      wait_in    = wait_ff;
      prior_in   = prior_ff;
      unknown_in = unknown_ff;
      held_in    = held_ff;
      since_in   = since_ff;
      last_in    = last_ff;
      rsp        = '{status: ST_NONE, left_click: 1'b0, right_click: 1'b0,
                     move_x: '0, move_y: '0};
      unique case (op_type'(req.opcode))
         OP_ENTER: begin
            prior_in   = ctrl;
            unknown_in = 1'b0;
            held_in    = '0;
            since_in   = '0;
            last_in    = '0;
            active_in  = 1'b1;
            wait_in    = (req.keys != '0);
         end
         OP_LEAVE: begin
            if (active_ff) begin
               active_in  = 1'b0;
               unknown_in = 1'b1;
               held_in    = '0;
               rsp.status = ST_REPORT;
            end
         end
         OP_HANDLE: begin
            if (!active_ff) begin
               rsp.status = ST_INACTIVE;
            end else if (wait_ff) begin
               if (ctrl == '0) begin
                  wait_in    = 1'b0;
                  prior_in   = '0;
                  unknown_in = 1'b0;
               end
            end else begin
               held_in  = dirs;
               since_in = since_eff;
               last_in  = last_eff;
               if (changed || due) begin
                  if (dirs != '0) begin
                     last_in = req.now_ms;
                     if (dirs[KEY_RIGHT]) rsp.move_x = rsp.move_x + step;
                     if (dirs[KEY_LEFT])  rsp.move_x = rsp.move_x - step;
                     if (dirs[KEY_DOWN])  rsp.move_y = rsp.move_y + step;
                     if (dirs[KEY_UP])    rsp.move_y = rsp.move_y - step;
                  end
                  prior_in        = ctrl;
                  unknown_in      = 1'b0;
                  rsp.status      = ST_REPORT;
                  rsp.left_click  = ctrl[KEY_LCLICK];
                  rsp.right_click = ctrl[KEY_RCLICK];
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= 1'b0;
         wait_ff    <= 1'b0;
         prior_ff   <= '0;
         unknown_ff <= 1'b1;
         held_ff    <= '0;
         since_ff   <= '0;
         last_ff    <= '0;
      end else if (fire) begin
         active_ff  <= active_in;
         wait_ff    <= wait_in;
         prior_ff   <= prior_in;
         unknown_ff <= unknown_in;
         held_ff    <= held_in;
         since_ff   <= since_in;
         last_ff    <= last_in;
      end
   end

endmodule

@@ hw/rtl/keypad_mouse_emulator.sv @@
// ----------------------------------------------------------------------------
// keypad_mouse_emulator
// Turns timestamped keypad samples into relative mouse reports.
// ----------------------------------------------------------------------------
//  Port group | Direction | Contents
//  req_*      | in        | opcode, keys, now_ms; valid/stall
//  rsp_*      | out       | status, clicks, move_x, move_y; valid/stall
//  csr_*      | in        | write enable, index, data; no read-back
//
//  A transaction is registered on acceptance and its result is registered
//  when the result register is free; one transaction can be accepted
//  every cycle unless the result side stalls. The whole decision,
//  including the reciprocal multiply for the hold-time speed, sits between
//  those two registers. A stalled result holds the input register; the
//  input side stalls only while both registers are full. Reset is
//  synchronous and restores the register defaults and the inactive mode.
// ----------------------------------------------------------------------------
module keypad_mouse_emulator (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic [1:0]                              req_opcode,
   input  logic [kme_pkg::KEYS_W-1:0]              req_keys,
   input  logic [kme_pkg::TIME_W-1:0]              req_now_ms,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic [1:0]                              rsp_status,
   output logic                                    rsp_left_click,
   output logic                                    rsp_right_click,
   output logic signed [kme_pkg::MOVE_W-1:0]       rsp_move_x,
   output logic signed [kme_pkg::MOVE_W-1:0]       rsp_move_y,
   input  logic                                    csr_write,
   input  logic [kme_pkg::CSR_IDX_W-1:0]           csr_index,
   input  logic [kme_pkg::CSR_DAT_W-1:0]           csr_wdata
);
   import kme_pkg::*;

   logic    req_valid_ff, req_valid_in;
   req_type req_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;
   cfg_type cfg_ff;
   logic    out_free;
   logic    fire;
   logic    accept;

   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign fire         = req_valid_ff && out_free;
   assign req_stall    = req_valid_ff && !out_free;
   assign accept       = req_valid && !req_stall;
   assign req_valid_in = accept || (req_valid_ff && !fire);
   assign rsp_valid_in = fire || (rsp_valid_ff && rsp_stall);

   kme_engine u_engine (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .req   (req_ff),
      .cfg   (cfg_ff),
      .rsp   (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= '{opcode: req_opcode, keys: req_keys, now_ms: req_now_ms};
      end
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base_speed <= BASE_SPEED_RST;
         cfg_ff.max_speed  <= MAX_SPEED_RST;
         cfg_ff.period     <= PERIOD_RST;
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_BASE_SPEED: cfg_ff.base_speed <= csr_wdata[SPEED_W-1:0];
            CSR_MAX_SPEED:  cfg_ff.max_speed  <= csr_wdata[SPEED_W-1:0];
            CSR_PERIOD:     cfg_ff.period     <= csr_wdata[PERIOD_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_ff.status;
   assign rsp_left_click  = rsp_ff.left_click;
   assign rsp_right_click = rsp_ff.right_click;
   assign rsp_move_x      = rsp_ff.move_x;
   assign rsp_move_y      = rsp_ff.move_y;

endmodule

@@ hw/rtl/kme_checker.sv @@
// ----------------------------------------------------------------------------
// kme_checker
// Port-level checks for the keypad mouse emulator, bound to the top level.
// ----------------------------------------------------------------------------
module kme_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic [1:0]                        rsp_status,
   input  logic                              rsp_left_click,
   input  logic                              rsp_right_click,
   input  logic signed [kme_pkg::MOVE_W-1:0] rsp_move_x,
   input  logic signed [kme_pkg::MOVE_W-1:0] rsp_move_y
);
   import kme_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) &&
         $stable(rsp_move_x) && $stable(rsp_move_y) &&
         $stable(rsp_left_click) && $stable(rsp_right_click))
      else $error("Stalled result transaction changed.");

   a_quiet_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_REPORT) |->
         !rsp_left_click && !rsp_right_click &&
         (rsp_move_x == '0) && (rsp_move_y == '0))
      else $error("Non-report transaction carries report fields.");

   a_move_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_move_x != MOVE_W'(8'h80)) && (rsp_move_y != MOVE_W'(8'h80)))
      else $error("Move value outside the symmetric range.");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("Result valid right after reset.");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("Input stalled while the result side can move.");

endmodule

bind keypad_mouse_emulator kme_checker u_kme_checker (.*);

@@ verif/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Keypad mouse emulator testbench
// Drives handle, enter and leave transactions through the valid/stall
// request channel, predicts every mouse report from a behavioral model
// kept in step with the register settings, and compares each accepted
// response field by field. Directed tests cover mode changes, release
// waiting, cancelling directions, speed ramping and register extremes.
// Randomized keypad sessions then run under several idling mixes.
// ----------------------------------------------------------------------------
module testbench;
   import kme_pkg::*;

   localparam logic [1:0]           OP_RESERVED       = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED        = 2'd3;
   localparam int                   HOLDOFF_CYCLES    = 64;
   localparam int                   WATCHDOG_LIMIT    = 2000;
   localparam int                   ITEMS_PER_SETTING = 210;

   logic                     clock           = 1'b0;
   logic                     reset           = 1'b1;
   logic                     req_valid       = 1'b0;
   logic                     req_stall;
   logic [1:0]               req_opcode      = '0;
   logic [KEYS_W-1:0]        req_keys        = '0;
   logic [TIME_W-1:0]        req_now_ms      = '0;
   logic                     rsp_valid;
   logic                     rsp_stall       = 1'b0;
   logic [1:0]               rsp_status;
   logic                     rsp_left_click;
   logic                     rsp_right_click;
   logic signed [MOVE_W-1:0] rsp_move_x;
   logic signed [MOVE_W-1:0] rsp_move_y;
   logic                     csr_write       = 1'b0;
   logic [CSR_IDX_W-1:0]     csr_index       = '0;
   logic [CSR_DAT_W-1:0]     csr_wdata       = '0;

   // Predicted mouse emulator state and register settings.
   logic                mouse_on         = 1'b0;
   logic                await_release    = 1'b0;
   logic [CTRL_W-1:0]   last_controls    = '0;
   logic                controls_unknown = 1'b1;
   logic [DIR_W-1:0]    held_dirs        = '0;
   logic [TIME_W-1:0]   dirs_since_ms    = '0;
   logic [TIME_W-1:0]   last_step_ms     = '0;
   logic [SPEED_W-1:0]  cfg_base         = BASE_SPEED_RST;
   logic [SPEED_W-1:0]  cfg_max          = MAX_SPEED_RST;
   logic [PERIOD_W-1:0] cfg_period       = PERIOD_RST;

   rsp_type expected_reports[$];
   int      mismatch_count = 0;
   int      send_idle_pct  = 0;
   int      recv_idle_pct  = 0;
   logic    holdoff_req    = 1'b0;
   int      holdoff_count  = 0;
   int      quiet_cycles   = 0;

   keypad_mouse_emulator i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_keys        (req_keys),
      .req_now_ms      (req_now_ms),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_left_click  (rsp_left_click),
      .rsp_right_click (rsp_right_click),
      .rsp_move_x      (rsp_move_x),
      .rsp_move_y      (rsp_move_y),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic rsp_type predict_report(input logic [1:0] op,
                                              input logic [KEYS_W-1:0] keys,
                                              input logic [TIME_W-1:0] now);
      rsp_type           report;
      logic [CTRL_W-1:0] controls;
      logic [DIR_W-1:0]  dirs;
      logic [TIME_W-1:0] speed;
      logic [TIME_W-1:0] elapsed;
      logic              changed;
      logic              due;
      int                step;
      int                dx;
      int                dy;
      report   = '0;
      controls = keys[CTRL_W-1:0];
      dirs     = controls[DIR_W-1:0];
      dx       = 0;
      dy       = 0;
      if (op == OP_ENTER) begin
         last_controls    = controls;
         controls_unknown = 1'b0;
         held_dirs        = '0;
         dirs_since_ms    = '0;
         last_step_ms     = '0;
         mouse_on         = 1'b1;
         await_release    = (keys != '0);
         return report;
      end
      if (op == OP_LEAVE) begin
         if (mouse_on) begin
            mouse_on         = 1'b0;
            controls_unknown = 1'b1;
            held_dirs        = '0;
            report.status    = ST_REPORT;
         end
         return report;
      end
      if (op == OP_RESERVED)
         return report;
      if (!mouse_on) begin
         report.status = ST_INACTIVE;
         return report;
      end
      if (await_release) begin
         if (controls == '0) begin
            await_release    = 1'b0;
            last_controls    = '0;
            controls_unknown = 1'b0;
         end
         return report;
      end
      if (dirs != held_dirs) begin
         held_dirs     = dirs;
         dirs_since_ms = now;
         last_step_ms  = '0;
      end
      elapsed = now - last_step_ms;
      changed = controls_unknown || (controls != last_controls);
      due     = (dirs != '0) && ((last_step_ms == '0) || (elapsed >= cfg_period));
      if (!changed && !due)
         return report;
      if (dirs != '0) begin
         speed = cfg_base + (now - dirs_since_ms) / SPEED_STEP_MS;
         if (speed > cfg_max)
            speed = cfg_max;
         step = int'(speed);
         if (dirs[KEY_LEFT])  dx -= step;
         if (dirs[KEY_RIGHT]) dx += step;
         if (dirs[KEY_UP])    dy -= step;
         if (dirs[KEY_DOWN])  dy += step;
         last_step_ms = now;
      end
      last_controls      = controls;
      controls_unknown   = 1'b0;
      report.status      = ST_REPORT;
      report.left_click  = controls[KEY_LCLICK];
      report.right_click = controls[KEY_RCLICK];
      report.move_x      = dx[MOVE_W-1:0];
      report.move_y      = dy[MOVE_W-1:0];
      return report;
   endfunction

   function automatic logic [KEYS_W-1:0] random_keys();
      int pick;
      pick = $urandom_range(99);
      if (pick < 12) return '0;
      if (pick < 60) return KEYS_W'($urandom_range(15));
      if (pick < 92) return KEYS_W'($urandom_range(63));
      return KEYS_W'($urandom_range(127));
   endfunction

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_reports.size() == 0) begin
            $display("%0t: unexpected transaction, expected none, actual status %0d",
                     $time, rsp_status);
            mismatch_count++;
         end else begin
            want = expected_reports.pop_front();
            check_field("status", int'(want.status), int'(rsp_status));
            check_field("left_click", int'(want.left_click), int'(rsp_left_click));
            check_field("right_click", int'(want.right_click), int'(rsp_right_click));
            check_field("move_x", int'(want.move_x), int'(rsp_move_x));
            check_field("move_y", int'(want.move_y), int'(rsp_move_y));
         end
      end
   end

   always @(posedge clock) begin
      if (holdoff_req && holdoff_count < HOLDOFF_CYCLES) begin
         rsp_stall     <= 1'b1;
         holdoff_count <= holdoff_count + 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         if (!holdoff_req)
            holdoff_count <= 0;
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic send_item(input logic [1:0] op, input logic [KEYS_W-1:0] keys,
                            input logic [TIME_W-1:0] now);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_opcode <= op;
      req_keys   <= keys;
      req_now_ms <= now;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      expected_reports.push_back(predict_report(op, keys, now));
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_reports.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_idling(input int send_pct, input int recv_pct);
      send_idle_pct = send_pct;
      recv_idle_pct <= recv_pct;
   endtask

   task automatic set_config(input logic [SPEED_W-1:0] base, input logic [SPEED_W-1:0] top,
                             input logic [PERIOD_W-1:0] period);
      csr_write <= 1'b1;
      csr_index <= CSR_BASE_SPEED;
      csr_wdata <= CSR_DAT_W'(base);
      @(posedge clock);
      csr_index <= CSR_MAX_SPEED;
      csr_wdata <= CSR_DAT_W'(top);
      @(posedge clock);
      csr_index <= CSR_PERIOD;
      csr_wdata <= period;
      @(posedge clock);
      csr_index <= CSR_UNUSED;
      csr_wdata <= CSR_DAT_W'($urandom());
      @(posedge clock);
      csr_write  <= 1'b0;
      cfg_base   = base;
      cfg_max    = top;
      cfg_period = period;
   endtask

   task automatic test_inactive_and_unused();
      send_item(OP_HANDLE, 7'h7F, 32'hFFFF_FFFF);
      send_item(OP_LEAVE, 7'h00, 32'h0000_0000);
      send_item(OP_RESERVED, 7'h7F, 32'h1234_5678);
   endtask

   task automatic test_enter_with_keys_held();
      send_item(OP_ENTER, 7'h40, 32'd100);
      send_item(OP_HANDLE, 7'h21, 32'd110);
      send_item(OP_HANDLE, 7'h40, 32'd120);
      send_item(OP_HANDLE, 7'h00, 32'd130);
   endtask

   task automatic test_directions_and_speed();
      send_item(OP_ENTER, 7'h00, 32'd1000);
      send_item(OP_HANDLE, 7'h0F, 32'd1000);
      send_item(OP_HANDLE, 7'h35, 32'd1010);
      send_item(OP_HANDLE, 7'h35, 32'd1910);
      send_item(OP_HANDLE, 7'h35, 32'd1915);
      send_item(OP_LEAVE, 7'h35, 32'd1920);
   endtask

   task automatic test_move_at_time_zero();
      send_item(OP_ENTER, 7'h00, 32'd0);
      send_item(OP_HANDLE, 7'h08, 32'd0);
      send_item(OP_HANDLE, 7'h08, 32'd1);
   endtask

   task automatic test_config_extremes();
      wait_idle();
      set_config(7'd127, 7'd0, 16'hFFFF);
      send_item(OP_ENTER, 7'h00, 32'd7);
      send_item(OP_HANDLE, 7'h02, 32'hFFFF_FF00);
      wait_idle();
      set_config(7'd100, 7'd127, 16'h0000);
      send_item(OP_HANDLE, 7'h08, 32'hFFFF_FFF0);
      send_item(OP_HANDLE, 7'h08, 32'h0000_0010);
      send_item(OP_HANDLE, 7'h08, 32'h0000_0010);
      wait_idle();
      set_config(7'd0, 7'd127, 16'd1);
      send_item(OP_HANDLE, 7'h01, 32'd5);
      send_item(OP_HANDLE, 7'h01, 32'd36005);
      send_item(OP_LEAVE, 7'h00, 32'd36010);
   endtask

   task automatic test_backpressure();
      logic [TIME_W-1:0] now;
      int                i;
      wait_idle();
      set_config(BASE_SPEED_RST, MAX_SPEED_RST, PERIOD_RST);
      set_idling(0, 0);
      now = 32'd5000;
      holdoff_req <= 1'b1;
      send_item(OP_ENTER, 7'h00, now);
      for (i = 0; i < 14; i++) begin
         now += 32'd13;
         send_item(OP_HANDLE, (i < 7) ? 7'h09 : 7'h26, now);
      end
      send_item(OP_LEAVE, 7'h00, now);
      wait_idle();
      holdoff_req <= 1'b0;
   endtask

   task automatic test_random_traffic(input int send_pct, input int recv_pct);
      logic [TIME_W-1:0] now;
      logic [KEYS_W-1:0] keys;
      int                setting;
      int                sent;
      int                run_len;
      int                pick;
      int                i;
      set_idling(send_pct, recv_pct);
      for (setting = 0; setting < 3; setting++) begin
         wait_idle();
         if (setting == 0)
            set_config(SPEED_W'($urandom_range(6)), SPEED_W'($urandom_range(4, 30)),
                       PERIOD_W'($urandom_range(1, 50)));
         else if (setting == 1)
            set_config(SPEED_W'($urandom_range(127)), SPEED_W'($urandom_range(127)),
                       ($urandom_range(1) != 0) ? PERIOD_W'($urandom_range(1, 200))
                                                : PERIOD_W'($urandom_range(1, 65535)));
         else
            set_config(($urandom_range(1) != 0) ? 7'd127 : 7'd0,
                       ($urandom_range(1) != 0) ? 7'd127 : 7'd0,
                       ($urandom_range(1) != 0) ? 16'hFFFF : 16'd1);
         now  = $urandom();
         sent = 0;
         while (sent < ITEMS_PER_SETTING) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
               case ($urandom_range(3))
                  0: send_item(OP_RESERVED, random_keys(), $urandom());
                  1: send_item(OP_HANDLE, random_keys(), $urandom());
                  2: send_item(OP_LEAVE, random_keys(), $urandom());
                  default: send_item(OP_ENTER, random_keys(), $urandom());
               endcase
            end else begin
               keys = ($urandom_range(4) == 0) ? random_keys() : '0;
               send_item(OP_ENTER, keys, now);
               sent++;
               run_len = $urandom_range(4, 40);
               for (i = 0; i < run_len; i++) begin
                  pick = $urandom_range(99);
                  if (pick < 30)
                     keys = random_keys();
                  pick = $urandom_range(99);
                  if (pick < 90)
                     now += $urandom_range(45);
                  else if (pick < 98)
                     now += $urandom_range(100, 3000);
                  else
                     now += $urandom();
                  send_item(OP_HANDLE, keys, now);
                  sent++;
               end
               if ($urandom_range(99) < 75) begin
                  send_item(OP_LEAVE, keys, now);
                  sent++;
               end
            end
         end
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      set_idling(8, 47);
      test_inactive_and_unused();
      test_enter_with_keys_held();
      test_directions_and_speed();
      test_move_at_time_zero();
      test_config_extremes();
      test_backpressure();
      test_random_traffic(8, 47);
      test_random_traffic(47, 8);
      test_random_traffic(0, 0);
      wait_idle();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && expected_reports.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

@@ keypad_mouse_emulator.f @@
hw/rtl/kme_pkg.sv
hw/rtl/kme_speed.sv
hw/rtl/kme_engine.sv
hw/rtl/keypad_mouse_emulator.sv
hw/rtl/kme_checker.sv
verif/testbench.sv
